### rtl/srtp_irc_pkg.sv
// Shared types and constants for the SRTP index estimation and replay check block.
package srtp_irc_pkg;

   // Field widths fixed by the packet format
   localparam int SEQ_W   = 16;
   localparam int ROC_W   = 32;
   localparam int INDEX_W = ROC_W + SEQ_W;
   localparam int DELTA_W = SEQ_W + 2;   // signed index distance, |delta| < 2^17
   localparam int AGE_W   = SEQ_W + 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Half of the sequence number range
   localparam logic [SEQ_W:0] HALF_RANGE = 17'd32768;

   // Operation codes
   localparam logic OP_CHECK  = 1'b0;
   localparam logic OP_COMMIT = 1'b1;

   // Verdict codes
   typedef logic [2:0] verdict_type;
   localparam verdict_type VERDICT_AHEAD       = 3'd0;
   localparam verdict_type VERDICT_UNSEEN      = 3'd1;
   localparam verdict_type VERDICT_REPLAYED    = 3'd2;
   localparam verdict_type VERDICT_TOO_OLD     = 3'd3;
   localparam verdict_type VERDICT_UNPROTECTED = 3'd4;

   // Configuration register indexes
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_SECURITY_OFF     = 2'd0;
   localparam csr_index_type CSR_INITIAL_ROLLOVER = 2'd1;
   localparam csr_index_type CSR_INITIAL_SEQUENCE = 2'd2;

   // One result word
   typedef struct packed {
      logic                 accepted;
      verdict_type          verdict;
      logic [INDEX_W-1:0]   estimated_index;
   } rsp_word_type;

   // Front to queue handoff
   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } push_type;

endpackage

### rtl/srtp_irc_ifs.sv
// Channel interfaces: request, response and configuration write.
interface srtp_irc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic [srtp_irc_pkg::SEQ_W-1:0] sequence_number;

   modport source (output valid, output operation, output sequence_number, input ready);
   modport sink   (input valid, input operation, input sequence_number, output ready);
endinterface

interface srtp_irc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            accepted;
   srtp_irc_pkg::verdict_type       verdict;
   logic [srtp_irc_pkg::INDEX_W-1:0] estimated_index;

   modport source (output valid, output accepted, output verdict, output estimated_index,
                   input ready);
   modport sink   (input valid, input accepted, input verdict, input estimated_index,
                   output ready);
endinterface

interface srtp_irc_csr_if;
   logic                                valid;
   logic                                ready;
   srtp_irc_pkg::csr_index_type         index;
   logic [srtp_irc_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/srtp_index_replay_check.sv
// Top level of the SRTP packet index estimation and replay check block.
//
// Request channel (req_bus): one word per RTP packet, carrying the 16-bit
// sequence number and an operation, check only or commit. Each word yields
// exactly one response word (rsp_bus): accepted flag, verdict and the 48-bit
// estimated packet index (guessed rollover counter over the sequence number).
// Commit words advance the rollover counter, highest sequence and the replay
// window of WINDOW_SIZE bits.
// The result of an accepted word is written into the queue and offered on
// rsp_bus from its registers. Throughput is one word per cycle while the queue
// has room; the rollover guess, window classification and window update are
// all combinational, so the next word sees the committed state.
// A two-word queue sits in front of the response port; when the receiver
// stalls it fills and req_bus.ready drops, and resumes as words drain.
// Configuration (csr_bus) is always ready: index 0 security off, 1 initial
// rollover (also clears the window), 2 initial highest sequence. Write it
// only while no request is in flight.
// Reset clears the tracking state, the window and the queue.
module srtp_index_replay_check #(
   parameter int WINDOW_SIZE = 64
) (
   input  logic             clock,
   input  logic             reset,
   srtp_irc_req_if.sink     req_bus,
   srtp_irc_rsp_if.source   rsp_bus,
   srtp_irc_csr_if.sink     csr_bus
);

   srtp_irc_pkg::push_type push;
   logic                   room;

   srtp_irc_front #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .room    (room),
      .push    (push)
   );

   srtp_irc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .room    (room),
      .rsp_bus (rsp_bus)
   );

endmodule

### rtl/srtp_irc_front.sv
// Front end: rollover guess, window classification, tracking state and config writes.
module srtp_irc_front #(
   parameter int WINDOW_SIZE = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   srtp_irc_req_if.sink            req_bus,
   srtp_irc_csr_if.sink            csr_bus,
   input  logic                    room,
   output srtp_irc_pkg::push_type  push
);

   localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam logic signed [srtp_irc_pkg::DELTA_W-1:0] WIN_DELTA =
      srtp_irc_pkg::DELTA_W'(WINDOW_SIZE);
   localparam logic [srtp_irc_pkg::AGE_W-1:0] WIN_AGE = srtp_irc_pkg::AGE_W'(WINDOW_SIZE);
   localparam logic signed [srtp_irc_pkg::DELTA_W-1:0] WRAP =
      srtp_irc_pkg::DELTA_W'(65536);

   // Tracking state
   logic                                security_off_ff, security_off_in;
   logic [srtp_irc_pkg::ROC_W-1:0]      rollover_ff, rollover_in;
   logic [srtp_irc_pkg::SEQ_W-1:0]      highest_ff, highest_in;
   logic [WINDOW_SIZE-1:0]              seen_ff, seen_in;

   logic                                take;
   logic [srtp_irc_pkg::SEQ_W-1:0]      seq;
   logic signed [srtp_irc_pkg::DELTA_W-1:0] diff, delta;
   logic                                adj_down, adj_up;
   logic [srtp_irc_pkg::ROC_W-1:0]      guess;
   logic                                ahead, big_jump, in_window, hit;
   logic [srtp_irc_pkg::AGE_W-1:0]      age;
   logic [IDX_W-1:0]                    age_idx;
   srtp_irc_pkg::verdict_type           verdict;

   assign req_bus.ready = room;
   assign csr_bus.ready = 1'b1;
   assign take = req_bus.valid && room;
   assign seq  = req_bus.sequence_number;

   // Rollover guess by half-range comparison
   always_comb begin
      diff = $signed({2'b00, seq}) - $signed({2'b00, highest_ff});
      adj_down = 1'b0;
      adj_up   = 1'b0;
      if (!highest_ff[srtp_irc_pkg::SEQ_W-1]) begin
         adj_down = diff > $signed({1'b0, srtp_irc_pkg::HALF_RANGE});
      end else begin
         adj_up = {1'b0, highest_ff[srtp_irc_pkg::SEQ_W-2:0]} > seq;
      end
      if (adj_down) begin
         guess = rollover_ff - srtp_irc_pkg::ROC_W'(1);
         delta = diff - WRAP;
      end else if (adj_up) begin
         guess = rollover_ff + srtp_irc_pkg::ROC_W'(1);
         delta = diff + WRAP;
      end else begin
         guess = rollover_ff;
         delta = diff;
      end
   end

   // Classification against the window
   always_comb begin
      ahead     = !delta[srtp_irc_pkg::DELTA_W-1] && (delta != '0);
      big_jump  = delta >= WIN_DELTA;
      age       = srtp_irc_pkg::AGE_W'(-delta);
      in_window = age < WIN_AGE;
      age_idx   = age[IDX_W-1:0];
      hit       = seen_ff[age_idx];
      priority if (security_off_ff) begin
         verdict = srtp_irc_pkg::VERDICT_UNPROTECTED;
      end else if (ahead) begin
         verdict = srtp_irc_pkg::VERDICT_AHEAD;
      end else if (!in_window) begin
         verdict = srtp_irc_pkg::VERDICT_TOO_OLD;
      end else if (hit) begin
         verdict = srtp_irc_pkg::VERDICT_REPLAYED;
      end else begin
         verdict = srtp_irc_pkg::VERDICT_UNSEEN;
      end
   end

   // Result word to the queue
   always_comb begin
      push.valid                = take;
      push.word.verdict         = verdict;
      push.word.accepted        = (verdict != srtp_irc_pkg::VERDICT_REPLAYED) &&
                                  (verdict != srtp_irc_pkg::VERDICT_TOO_OLD);
      push.word.estimated_index = {guess, seq};
   end

   // Next state: config writes, then commits
   always_comb begin
      security_off_in = security_off_ff;
      rollover_in     = rollover_ff;
      highest_in      = highest_ff;
      seen_in         = seen_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            srtp_irc_pkg::CSR_SECURITY_OFF: begin
               security_off_in = csr_bus.data[0];
            end
            srtp_irc_pkg::CSR_INITIAL_ROLLOVER: begin
               rollover_in = csr_bus.data;
               seen_in     = '0;
            end
            srtp_irc_pkg::CSR_INITIAL_SEQUENCE: begin
               highest_in = csr_bus.data[srtp_irc_pkg::SEQ_W-1:0];
            end
            default: begin
            end
         endcase
      end else if (take && (req_bus.operation == srtp_irc_pkg::OP_COMMIT)) begin
         if (ahead) begin
            if (big_jump) begin
               seen_in = WINDOW_SIZE'(1);
            end else begin
               seen_in = (seen_ff << delta[IDX_W-1:0]) | WINDOW_SIZE'(1);
            end
            rollover_in = guess;
            highest_in  = seq;
         end else if (in_window) begin
            seen_in = seen_ff | (WINDOW_SIZE'(1) << age_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         security_off_ff <= 1'b0;
         rollover_ff     <= '0;
         highest_ff      <= '0;
         seen_ff         <= '0;
      end else begin
         security_off_ff <= security_off_in;
         rollover_ff     <= rollover_in;
         highest_ff      <= highest_in;
         seen_ff         <= seen_in;
      end
   end

endmodule

### rtl/srtp_irc_queue.sv
// Back end: two-word result queue driving the registered response channel.
module srtp_irc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  srtp_irc_pkg::push_type  push,
   output logic                    room,
   srtp_irc_rsp_if.source          rsp_bus
);

   srtp_irc_pkg::rsp_word_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   srtp_irc_pkg::rsp_word_type head;

   assign room = count_ff != 2'd2;
   assign pop  = rsp_bus.valid && rsp_bus.ready;
   assign head = entry_ff[rd_ptr_ff];

   assign rsp_bus.valid           = count_ff != 2'd0;
   assign rsp_bus.accepted        = head.accepted;
   assign rsp_bus.verdict         = head.verdict;
   assign rsp_bus.estimated_index = head.estimated_index;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push.valid;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push.valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.word;
      end
   end

endmodule
